>>> rtl/pshm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the page slot hash map
// no dependencies
package pshm_pkg;

  localparam int FID_W  = 16;
  localparam int PG_W   = 24;
  localparam int KEY_W  = FID_W + PG_W;
  localparam int SLOT_W = 10;
  localparam int HASH_W = 16;

  localparam int DEF_NUM_BUCKETS = 64;
  localparam int DEF_CAPACITY    = 256;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_DUP      = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fl_cmd_t;

  typedef struct packed {
    logic full;
  } fl_stat_t;

endpackage

>>> rtl/pshm_free.sv
`timescale 1ns / 1ps
// free node allocator: stack of released nodes plus a counter of never used nodes
// depends on pshm_pkg
module pshm_free
  import pshm_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int NW = $clog2(CAPACITY + 1),
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fl_cmd_t       cmd,
  input  logic [NW-1:0] push_idx,
  output logic [NW-1:0] alloc_idx,
  output fl_stat_t      stat
);

  logic [IW-1:0] stk_mem [CAPACITY];
  logic [IW-1:0] rd_q;
  logic [NW-1:0] sp_r, sp_nxt;
  logic [NW-1:0] fresh_r, fresh_nxt;
  logic [IW-1:0] top_addr;

  assign top_addr = IW'(sp_r - NW'(1));

  always_ff @(posedge clk) begin
    rd_q <= stk_mem[top_addr];
    if (cmd.push) begin
      stk_mem[sp_r[IW-1:0]] <= push_idx[IW-1:0];
    end
  end

  always_comb begin
    sp_nxt    = sp_r;
    fresh_nxt = fresh_r;
    if (cmd.push) begin
      sp_nxt = sp_r + NW'(1);
    end else if (cmd.pop) begin
      if (sp_r != '0) begin
        sp_nxt = sp_r - NW'(1);
      end else begin
        fresh_nxt = fresh_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r    <= '0;
      fresh_r <= '0;
    end else begin
      sp_r    <= sp_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  assign alloc_idx = (sp_r != '0) ? {1'b0, rd_q} : fresh_r;
  assign stat.full = (sp_r == '0) && (fresh_r == NW'(CAPACITY));

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= NW'(CAPACITY))
    else $error("fresh counter past capacity");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= fresh_r)
    else $error("more free nodes stacked than ever allocated");
  a_no_pop_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !stat.full)
    else $error("allocation from empty free list");

endmodule

>>> rtl/page_slot_hash_map_core.sv
`timescale 1ns / 1ps
// page slot hash map: bucket heads, node memories and the request sequencer
// depends on pshm_pkg and pshm_free
// sequence: hash, bucket head read, walk over the k nodes visited on the chain, then action;
// an insert that adds a node also passes the second insert state, and mode three goes straight to the result
// one request at a time: in_tready stays low until the result is handed on; a held result stalls in_tready
// reset: synchronous; afterwards every one of the NUM_BUCKETS buckets is cleared with in_tready low
module page_slot_hash_map_core
  import pshm_pkg::*;
#(
  parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
  parameter int CAPACITY    = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // file_id, page_number, slot_in
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // found, slot_out, status
);

  localparam int NW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [NW-1:0] NIL = NW'(CAPACITY);
  localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(NUM_BUCKETS) - 64'd1)
                                      / 64'(NUM_BUCKETS));

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_HASH = 8'b0000_0100,
    S_HEAD = 8'b0000_1000,
    S_WALK = 8'b0001_0000,
    S_ACT  = 8'b0010_0000,
    S_INS2 = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [BW-1:0]     clr_r;
  mode_t             mode_r;
  logic [KEY_W-1:0]  key_r;
  logic [SLOT_W-1:0] slin_r;
  logic [HASH_W-1:0] h_r, q_r;
  logic [BW-1:0]     b_r;
  logic [NW-1:0]     head_r, cur_r, prev_r, next_r, alloc_r;
  logic [SLOT_W-1:0] slot_r;
  logic              hit_r;
  logic              res_found_r;
  logic [SLOT_W-1:0] res_slot_r;
  status_t           res_stat_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_slot_r;
  status_t           out_stat_r;

  logic [FID_W-1:0]  in_fid;
  logic [PG_W-1:0]   in_pg;
  logic [HASH_W-1:0] in_hash;
  logic [48:0]       in_prod;
  logic [HASH_W-1:0] bucket_calc;

  logic [NW-1:0]     bkt_mem [NUM_BUCKETS];
  logic [NW-1:0]     bkt_q;
  logic              bkt_we;
  logic [BW-1:0]     bkt_waddr;
  logic [NW-1:0]     bkt_wdata;

  logic [KEY_W+SLOT_W-1:0] kv_mem [CAPACITY];
  logic [NW-1:0]     prev_mem [CAPACITY];
  logic [NW-1:0]     next_mem [CAPACITY];
  logic [KEY_W+SLOT_W-1:0] kv_q;
  logic [NW-1:0]     prev_q, next_q;
  logic [IW-1:0]     node_raddr;
  logic              kv_we, prev_we, next_we;
  logic [IW-1:0]     kv_waddr, prev_waddr, next_waddr;
  logic [NW-1:0]     prev_wdata, next_wdata;

  fl_cmd_t           fl_cmd;
  fl_stat_t          fl_stat;
  logic [NW-1:0]     alloc_idx;

  logic              res_load;
  logic              res_found_nxt;
  logic [SLOT_W-1:0] res_slot_nxt;
  status_t           res_stat_nxt;

  assign in_fid  = in_tdata[15:0];
  assign in_pg   = in_tdata[39:16];
  assign in_hash = in_fid ^ HASH_W'(in_pg[11:0]) ^ HASH_W'(in_pg[23:12]);
  assign in_prod = 49'(in_hash) * 49'(RECIP);
  assign bucket_calc = h_r - HASH_W'(32'(q_r) * 32'(NUM_BUCKETS));

  assign in_tready = (state_r == S_IDLE);

  pshm_free #(.CAPACITY(CAPACITY)) u_free (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fl_cmd),
    .push_idx  (cur_r),
    .alloc_idx (alloc_idx),
    .stat      (fl_stat)
  );

  always_ff @(posedge clk) begin
    bkt_q <= bkt_mem[bucket_calc[BW-1:0]];
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
  end

  always_ff @(posedge clk) begin
    kv_q   <= kv_mem[node_raddr];
    prev_q <= prev_mem[node_raddr];
    next_q <= next_mem[node_raddr];
    if (kv_we) begin
      kv_mem[kv_waddr] <= {key_r, slin_r};
    end
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    node_raddr    = (state_r == S_HEAD) ? bkt_q[IW-1:0] : next_q[IW-1:0];
    bkt_we        = 1'b0;
    bkt_waddr     = b_r;
    bkt_wdata     = NIL;
    kv_we         = 1'b0;
    kv_waddr      = alloc_idx[IW-1:0];
    prev_we       = 1'b0;
    prev_waddr    = alloc_idx[IW-1:0];
    prev_wdata    = NIL;
    next_we       = 1'b0;
    next_waddr    = alloc_idx[IW-1:0];
    next_wdata    = head_r;
    fl_cmd        = '0;
    res_load      = 1'b0;
    res_found_nxt = 1'b0;
    res_slot_nxt  = '0;
    res_stat_nxt  = ST_OK;
    unique case (state_r)
      S_CLR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_r;
        if (clr_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          if (mode_t'(in_tuser) == MODE_NOP) begin
            res_load  = 1'b1;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: state_nxt = S_HEAD;
      S_HEAD: begin
        state_nxt = (bkt_q == NIL) ? S_ACT : S_WALK;
      end
      S_WALK: begin
        if (kv_q[KEY_W+SLOT_W-1:SLOT_W] == key_r || next_q == NIL) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        res_load  = 1'b1;
        state_nxt = S_RESP;
        unique case (mode_r)
          MODE_FIND: begin
            res_found_nxt = hit_r;
            res_slot_nxt  = hit_r ? slot_r : '0;
            res_stat_nxt  = hit_r ? ST_OK : ST_NOTFOUND;
          end
          MODE_INSERT: begin
            if (hit_r) begin
              res_stat_nxt = ST_DUP;
            end else if (fl_stat.full) begin
              res_stat_nxt = ST_FULL;
            end else begin
              fl_cmd.pop = 1'b1;
              kv_we      = 1'b1;
              prev_we    = 1'b1;
              next_we    = 1'b1;
              bkt_we     = 1'b1;
              bkt_wdata  = alloc_idx;
              state_nxt  = S_INS2;
            end
          end
          MODE_REMOVE: begin
            if (!hit_r) begin
              res_stat_nxt = ST_NOTFOUND;
            end else begin
              fl_cmd.push = 1'b1;
              bkt_we      = (head_r == cur_r);
              bkt_wdata   = next_r;
              next_we     = (prev_r != NIL);
              next_waddr  = prev_r[IW-1:0];
              next_wdata  = next_r;
              prev_we     = (next_r != NIL);
              prev_waddr  = next_r[IW-1:0];
              prev_wdata  = prev_r;
            end
          end
          default: res_stat_nxt = ST_OK;
        endcase
      end
      S_INS2: begin
        prev_we    = (head_r != NIL);
        prev_waddr = head_r[IW-1:0];
        prev_wdata = alloc_r;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + BW'(1);
      end
      if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r <= mode_t'(in_tuser);
      key_r  <= {in_fid, in_pg};
      slin_r <= in_tdata[49:40];
      h_r    <= in_hash;
      q_r    <= in_prod[47:32];
    end
    if (state_r == S_HASH) begin
      b_r <= bucket_calc[BW-1:0];
    end
    if (state_r == S_HEAD) begin
      head_r <= bkt_q;
      cur_r  <= bkt_q;
      hit_r  <= 1'b0;
    end
    if (state_r == S_WALK) begin
      prev_r <= prev_q;
      next_r <= next_q;
      slot_r <= kv_q[SLOT_W-1:0];
      hit_r  <= (kv_q[KEY_W+SLOT_W-1:SLOT_W] == key_r);
      if (kv_q[KEY_W+SLOT_W-1:SLOT_W] != key_r && next_q != NIL) begin
        cur_r <= next_q;
      end
    end
    if (state_r == S_ACT) begin
      alloc_r <= alloc_idx;
    end
    if (res_load) begin
      res_found_r <= res_found_nxt;
      res_slot_r  <= res_slot_nxt;
      res_stat_r  <= res_stat_nxt;
    end
    if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
      out_stat_r  <= res_stat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_stat_r, out_slot_r, out_found_r};

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_stat_r == ST_OK)
    else $error("found result with error status");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    fl_cmd.pop |=> state_r == S_INS2)
    else $error("allocation outside insert");

endmodule
